// File: src/skrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrf_pkg: shared types and constants of the rate fusion filter
// Register map, reset values, divider request/response and saturation.
// ----------------------------------------------------------------------------
package skrf_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned QUOT_W = 32;
	localparam int unsigned DEN_W  = 33;
	localparam int unsigned NUM_W  = 64;

	typedef enum logic [1:0] {
		REG_PROCESS_VAR = 2'd0,
		REG_MEAS_VAR    = 2'd1,
		REG_INIT_VAR    = 2'd2
	} reg_idx_t;

	localparam logic [DATA_W-1:0] PROCESS_VAR_RST = 32'd262144;
	localparam logic [DATA_W-1:0] MEAS_VAR_RST    = 32'd32768;
	localparam logic [DATA_W-1:0] INIT_VAR_RST    = 32'd65536000;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  numer;
		logic [DEN_W-1:0]  denom;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	function automatic logic signed [31:0] sat_s32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if ((v[33] == v[32]) && (v[32] == v[31]))
			r = v[31:0];
		else if (v[33])
			r = 32'sh8000_0000;
		else
			r = 32'sh7FFF_FFFF;
		return r;
	endfunction

endpackage

// File: src/skrf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrf_div: serial restoring divider
// One quotient bit per cycle, 64-bit dividend over 33-bit divisor, 32-bit quotient.
// ----------------------------------------------------------------------------
module skrf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  skrf_pkg::div_req_t req,
	output skrf_pkg::div_rsp_t rsp
);
	import skrf_pkg::*;

	logic [DEN_W-1:0]  rem_q;
	logic [QUOT_W-1:0] low_q;
	logic [DEN_W-1:0]  den_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    trial;
	logic              fits;

	assign shifted = {rem_q, low_q[QUOT_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			low_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= {1'b0, req.numer[NUM_W-1:QUOT_W]};
				low_q  <= req.numer[QUOT_W-1:0];
				den_q  <= req.denom;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
				low_q <= {low_q[QUOT_W-2:0], fits};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = low_q;

endmodule

// File: src/scalar_kalman_rate_fusion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_rate_fusion: scalar Kalman filter fusing IMU and odometry rates
// IMU request: stored, no result. First odometry request: seeds, no result.
// Later odometry request: prediction, then gain and variance passes of the
// shared serial divider (skipped if the denominator is zero), then emit. No new
// request is taken until emit; a stalled earlier result holds the block in emit.
// Reset (arst_n low) loads register defaults, clears the estimate and rates.
// ----------------------------------------------------------------------------
module scalar_kalman_rate_fusion (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [skrf_pkg::ADDR_W-1:0]         paddr,
	input  logic [skrf_pkg::DATA_W-1:0]         pwdata,
	output logic [skrf_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic signed [31:0]                  rate_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [31:0]                  filtered_rate
);
	import skrf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_GAIN,
		ST_DIV_GAIN,
		ST_WAIT_GAIN,
		ST_MUL_VAR,
		ST_DIV_VAR,
		ST_WAIT_VAR,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [31:0]         process_var_q;
	logic [31:0]         meas_var_q;
	logic [31:0]         init_var_q;
	logic signed [31:0]  est_q;
	logic [31:0]         var_q;
	logic signed [31:0]  prev_q;
	logic signed [31:0]  imu_q;
	logic                first_q;
	logic                neg_q;
	logic [NUM_W-1:0]    prod_q;
	logic [DEN_W-1:0]    den_q;
	logic                out_valid_q;
	logic signed [31:0]  out_q;

	logic                wr_en;
	reg_idx_t            wr_idx;
	logic                in_acc;
	logic signed [33:0]  pred_sum;
	logic [32:0]         var_sum;
	logic signed [32:0]  diff;
	logic [31:0]         mag;
	logic [DEN_W-1:0]    den_sum;
	logic signed [33:0]  corr_sum;
	logic [31:0]         mul_a;
	logic [31:0]         mul_b;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	skrf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign wr_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_PROCESS_VAR: prdata = process_var_q;
			REG_MEAS_VAR:    prdata = meas_var_q;
			REG_INIT_VAR:    prdata = init_var_q;
			default:         prdata = '0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;

	assign pred_sum = 34'(est_q) + 34'(rate_sample) - 34'(prev_q);
	assign var_sum  = {1'b0, var_q} + {1'b0, process_var_q};
	assign diff     = 33'(imu_q) - 33'(est_q);
	assign mag      = diff[32] ? 32'(-diff) : 32'(diff);
	assign den_sum  = {1'b0, meas_var_q} + {1'b0, var_q};
	assign corr_sum = neg_q ? (34'(est_q) - {2'b00, div_rsp.quot})
	                        : (34'(est_q) + {2'b00, div_rsp.quot});

	assign mul_a = (state_q == ST_MUL_GAIN) ? var_q : meas_var_q;
	assign mul_b = (state_q == ST_MUL_GAIN) ? mag : var_q;

	assign div_req.start = (state_q == ST_DIV_GAIN) || (state_q == ST_DIV_VAR);
	assign div_req.numer = prod_q;
	assign div_req.denom = den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			process_var_q <= PROCESS_VAR_RST;
			meas_var_q    <= MEAS_VAR_RST;
			init_var_q    <= INIT_VAR_RST;
			est_q         <= '0;
			var_q         <= INIT_VAR_RST;
			prev_q        <= '0;
			imu_q         <= '0;
			first_q       <= 1'b1;
			neg_q         <= 1'b0;
			prod_q        <= '0;
			den_q         <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (wr_en) begin
				case (wr_idx)
					REG_PROCESS_VAR: process_var_q <= pwdata;
					REG_MEAS_VAR:    meas_var_q    <= pwdata;
					REG_INIT_VAR: begin
						init_var_q <= pwdata;
						if (first_q)
							var_q <= pwdata;
					end
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall && (state_q != ST_EMIT))
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!func) begin
							imu_q <= rate_sample;
						end else if (first_q) begin
							est_q   <= rate_sample;
							prev_q  <= rate_sample;
							first_q <= 1'b0;
						end else begin
							est_q   <= sat_s32(pred_sum);
							prev_q  <= rate_sample;
							var_q   <= var_sum[32] ? 32'hFFFF_FFFF : var_sum[31:0];
							state_q <= ST_MUL_GAIN;
						end
					end
				end
				ST_MUL_GAIN: begin
					neg_q   <= diff[32];
					prod_q  <= {32'd0, mul_a} * {32'd0, mul_b};
					den_q   <= den_sum;
					state_q <= (den_sum == '0) ? ST_EMIT : ST_DIV_GAIN;
				end
				ST_DIV_GAIN: begin
					state_q <= ST_WAIT_GAIN;
				end
				ST_WAIT_GAIN: begin
					if (div_rsp.done) begin
						est_q   <= sat_s32(corr_sum);
						state_q <= ST_MUL_VAR;
					end
				end
				ST_MUL_VAR: begin
					prod_q  <= {32'd0, mul_a} * {32'd0, mul_b};
					state_q <= ST_DIV_VAR;
				end
				ST_DIV_VAR: begin
					state_q <= ST_WAIT_VAR;
				end
				ST_WAIT_VAR: begin
					if (div_rsp.done) begin
						var_q   <= div_rsp.quot;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_q       <= est_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign filtered_rate = out_q;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for scalar_kalman_rate_fusion
// Drives IMU and odometry rate requests through the valid/stall port,
// programs the variances over APB, and tracks the filter state in its own
// predictor. Every filtered rate is compared with the predicted one, under
// mixed sender idling, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
	import skrf_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES = 1500;
	localparam int PHASE_ITEMS = 240;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic func;
	logic signed [31:0] rate_sample;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] filtered_rate;

	// predictor copy of registers and filter state
	bit [31:0] proc_var_q;
	bit [31:0] meas_var_q;
	bit [31:0] init_var_q;
	bit [31:0] var_q;
	logic signed [31:0] est_q;
	logic signed [31:0] prev_odo_q;
	logic signed [31:0] imu_q;
	bit seed_pending;

	logic signed [31:0] fused_rate_q[$];

	int send_idle_pct;
	int stall_pct;
	int hold_cycles;
	int quiet_cycles;
	int err_cnt;
	int imu_cnt;
	int odo_cnt;
	int result_cnt;
	int reg_writes;

	scalar_kalman_rate_fusion u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.rate_sample(rate_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered_rate(filtered_rate)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp_q16(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic void fuse_rate(bit is_odo, logic signed [31:0] r);
		longint diff;
		longint nxt;
		bit [63:0] mag;
		bit [63:0] corr;
		bit [63:0] vsum;
		bit [63:0] den;
		if (!is_odo) begin
			imu_q = r;
			return;
		end
		if (seed_pending) begin
			est_q = r;
			prev_odo_q = r;
			seed_pending = 1'b0;
			return;
		end
		est_q = clamp_q16(longint'(est_q) + (longint'(r) - longint'(prev_odo_q)));
		prev_odo_q = r;
		vsum = 64'(var_q) + 64'(proc_var_q);
		var_q = (vsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vsum[31:0];
		den = 64'(meas_var_q) + 64'(var_q);
		if (den != 0) begin
			diff = longint'(imu_q) - longint'(est_q);
			mag = (diff < 0) ? -diff : diff;
			corr = (64'(var_q) * mag) / den;
			nxt = (diff < 0) ? longint'(est_q) - longint'(corr)
			                 : longint'(est_q) + longint'(corr);
			est_q = clamp_q16(nxt);
			var_q = (64'(meas_var_q) * 64'(var_q)) / den;
		end
		fused_rate_q.push_back(est_q);
	endfunction

	// predict on every accepted request
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			if (func)
				odo_cnt++;
			else
				imu_cnt++;
			fuse_rate(func, rate_sample);
		end
	end

	always @(posedge clk) begin : chk_result
		logic signed [31:0] want;
		if (arst_n && out_valid && !out_stall) begin
			result_cnt++;
			if (fused_rate_q.size() == 0) begin
				err_cnt++;
				$error("filtered_rate: unexpected result %0d", filtered_rate);
			end else begin
				want = fused_rate_q.pop_front();
				if (filtered_rate !== want) begin
					err_cnt++;
					$error("filtered_rate: expected %0d, got %0d", want, filtered_rate);
				end
			end
		end
	end

	// receiver: long hold-off first, else random stall
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
			$display("** scalar_kalman_rate_fusion: FAILED **");
			$finish;
		end
	end

	task automatic send_item(bit f, logic signed [31:0] r);
		int gap;
		gap = 0;
		while (gap < 50 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		rate_sample <= r;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid, drain results, let the block go idle
	task automatic settle();
		in_valid <= 1'b0;
		while (fused_rate_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, bit [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PROCESS_VAR: proc_var_q = val;
			REG_MEAS_VAR: meas_var_q = val;
			REG_INIT_VAR: begin
				init_var_q = val;
				if (seed_pending)
					var_q = val;
			end
			default: ;
		endcase
		reg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_check(reg_idx_t idx, bit [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			err_cnt++;
			$error("prdata: expected %0h, got %0h", want, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_idling(int sender, int receiver);
		send_idle_pct = sender;
		stall_pct = receiver;
	endtask

	function automatic logic signed [31:0] pick_rate();
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $urandom;
			default: return int'($urandom_range(2097152)) - 1048576;
		endcase
	endfunction

	task automatic test_registers();
		cfg_check(REG_PROCESS_VAR, PROCESS_VAR_RST);
		cfg_check(REG_MEAS_VAR, MEAS_VAR_RST);
		cfg_check(REG_INIT_VAR, INIT_VAR_RST);
		// reloads the variance while the filter is unseeded
		cfg_write(REG_INIT_VAR, 32'h0010_0000);
		cfg_check(REG_INIT_VAR, 32'h0010_0000);
	endtask

	task automatic test_directed();
		set_idling(0, 0);
		send_item(1'b0, 32'sh7FFF_FFFF);
		send_item(1'b1, 32'sd0);
		send_item(1'b1, 32'sd0);
		send_item(1'b0, 32'sh8000_0000);
		send_item(1'b1, 32'sh7FFF_FFFF);
		send_item(1'b1, 32'sh8000_0000);
		send_item(1'b1, 32'sh7FFF_FFFF);
		send_item(1'b0, -32'sd1);
		send_item(1'b1, -32'sd1);
		send_item(1'b0, 32'sd0);
		send_item(1'b1, 32'sd1);
		send_item(1'b1, 32'sd65536);
		settle();
		// no effect on the variance once seeded
		cfg_write(REG_INIT_VAR, 32'hFFFF_FFFF);
		cfg_check(REG_INIT_VAR, 32'hFFFF_FFFF);
		send_item(1'b0, 32'sd131072);
		send_item(1'b1, 32'sd65536);
		settle();
		cfg_write(REG_PROCESS_VAR, 32'hFFFF_FFFF);
		cfg_write(REG_MEAS_VAR, 32'hFFFF_FFFF);
		send_item(1'b0, 32'sh5555_5555);
		send_item(1'b1, 32'shAAAA_AAAA);
		send_item(1'b1, 32'sh5555_5555);
		settle();
		cfg_write(REG_MEAS_VAR, 32'd1);
		cfg_write(REG_PROCESS_VAR, 32'd0);
		send_item(1'b0, 32'sh8000_0000);
		send_item(1'b1, 32'sh7FFF_FFFF);
		send_item(1'b1, 32'sd0);
		send_item(1'b1, 32'sd0);
		settle();
	endtask

	task automatic test_random();
		bit [31:0] pv;
		bit [31:0] mv;
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: pv = 32'd0;
				1: pv = 32'hFFFF_FFFF;
				2: pv = PROCESS_VAR_RST;
				default: pv = $urandom;
			endcase
			case (p / 2)
				0: mv = 32'd1;
				1: mv = 32'hFFFF_FFFF;
				2: mv = MEAS_VAR_RST;
				default: mv = $urandom_range(32'hFFFF_FFFF, 1);
			endcase
			cfg_write(REG_PROCESS_VAR, pv);
			cfg_write(REG_MEAS_VAR, mv);
			cfg_write(REG_INIT_VAR, $urandom);
			case (p % 4)
				0: set_idling(0, 0);
				1: set_idling(77, 0);
				2: set_idling(0, 77);
				default: set_idling(27, 27);
			endcase
			repeat (PHASE_ITEMS)
				send_item(1'($urandom_range(1)), pick_rate());
			settle();
		end
	endtask

	task automatic test_backpressure();
		set_idling(0, 0);
		cfg_write(REG_PROCESS_VAR, PROCESS_VAR_RST);
		cfg_write(REG_MEAS_VAR, MEAS_VAR_RST);
		hold_cycles = HOLD_CYCLES;
		for (int i = 0; i < 24; i++)
			send_item(i[0], pick_rate());
		settle();
	endtask

	initial begin
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		func <= 1'b0;
		rate_sample <= '0;
		arst_n <= 1'b0;
		proc_var_q = PROCESS_VAR_RST;
		meas_var_q = MEAS_VAR_RST;
		init_var_q = INIT_VAR_RST;
		var_q = INIT_VAR_RST;
		est_q = '0;
		prev_odo_q = '0;
		imu_q = '0;
		seed_pending = 1'b1;
		set_idling(0, 0);
		hold_cycles = 0;
		quiet_cycles = 0;
		err_cnt = 0;
		imu_cnt = 0;
		odo_cnt = 0;
		result_cnt = 0;
		reg_writes = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_registers();
		test_directed();
		test_backpressure();
		test_random();

		$display("covered %0d IMU and %0d odometry requests, %0d filtered rates checked",
			imu_cnt, odo_cnt, result_cnt);
		$display("%0d register writes incl. variance extremes; idle mixes none/77/77/27",
			reg_writes);
		if (err_cnt == 0)
			$display("** scalar_kalman_rate_fusion: PASSED **");
		else
			$display("** scalar_kalman_rate_fusion: FAILED **");
		$finish;
	end

endmodule

// File: scalar_kalman_rate_fusion.f
src/skrf_pkg.sv
src/skrf_div.sv
src/scalar_kalman_rate_fusion.sv
dv/tb.sv
